// ===== rtl/dma_request_ring_queue_macros.svh =====
// assertion macros for the dma request ring queue
`ifndef DMA_REQUEST_RING_QUEUE_MACROS_SVH
`define DMA_REQUEST_RING_QUEUE_MACROS_SVH
`ifndef SYNTHESIS
`define DRQ_ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("drq check failed");
`define DRQ_ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("drq check failed");
`else
`define DRQ_ASSERT_IMPL(label, clk, rst_n, a, c)
`define DRQ_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/drq_pkg.sv =====
// package: shared types and constants of the dma request ring queue
`default_nettype none
package drq_pkg;
  localparam int QueueDepth = 64;
  localparam int SlotW = 6;
  localparam logic [15:0] BudgetReset = 16'd40960;
  localparam logic [7:0] LineReset = 8'd224;

  localparam logic [2:0] ReqCopy = 3'd0;
  localparam logic [2:0] ReqFill = 3'd1;
  localparam logic [2:0] ReqDrain = 3'd2;
  localparam logic [2:0] ReqCheck = 3'd3;
  localparam logic [2:0] ReqAllEmpty = 3'd4;
  localparam logic [2:0] ReqClear = 3'd5;

  localparam logic [1:0] OpCopy32 = 2'd0;
  localparam logic [1:0] OpFill32 = 2'd1;
  localparam logic [1:0] OpCopy16 = 2'd2;
  localparam logic [1:0] OpFill16 = 2'd3;

  localparam logic [0:0] RegBudget = 1'd0;
  localparam logic [0:0] RegLine = 1'd1;

  // descriptor held by one cell
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dest;
    logic [15:0] size;
    logic [1:0] op;
    logic [31:0] value;
  } desc_t;

  // ring control broadcast to every cell
  typedef struct packed {
    logic rotate;
    logic load_head;
    logic free_head;
    logic clear;
    logic fill;
  } ring_ctl_t;

  typedef struct packed {
    logic [5:0] slot_number;
    logic enqueue_failed;
    logic busy_res;
    logic issued;
    logic [31:0] out_src;
    logic [31:0] out_dest;
    logic [15:0] out_size;
    logic [1:0] out_op;
    logic [31:0] out_value;
    logic last;
  } res_t;

  typedef struct packed {
    logic [2:0] req_type;
    logic [31:0] src_addr;
    logic [31:0] dest_addr;
    logic [15:0] xfer_size;
    logic wide_unit;
    logic [31:0] fill_value;
    logic [5:0] slot_index;
    logic [7:0] scan_line;
  } req_t;
endpackage
`default_nettype wire

// ===== rtl/drq_stream_if.sv =====
// valid/ready channel carrying one payload
`default_nettype none
interface drq_stream_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/drq_cell.sv =====
// one descriptor slot cell of the rotating ring
`default_nettype none
module drq_cell (
  input  wire logic              clk,
  input  wire drq_pkg::ring_ctl_t ctl,
  input  wire logic              is_head,
  input  wire drq_pkg::desc_t    prev_desc,
  input  wire drq_pkg::desc_t    load_desc,
  output drq_pkg::desc_t         desc
);
  drq_pkg::desc_t desc_r, desc_nxt;

  // rotate, load, free or clear
  always_comb begin
    desc_nxt = desc_r;
    if (ctl.clear) begin
      desc_nxt.src = '0;
      desc_nxt.dest = '0;
      desc_nxt.size = '0;
    end else if (ctl.rotate) begin
      desc_nxt = prev_desc;
    end else if (is_head && ctl.load_head) begin
      desc_nxt.dest = load_desc.dest;
      desc_nxt.size = load_desc.size;
      desc_nxt.op = load_desc.op;
      if (ctl.fill) desc_nxt.value = load_desc.value;
      else desc_nxt.src = load_desc.src;
    end else if (is_head && ctl.free_head) begin
      desc_nxt = '0;
    end
  end

  // payload storage; src, dest and size cleared at reset by the ring's sweep-free clear
  always_ff @(posedge clk) begin
    desc_r <= desc_nxt;
  end

  assign desc = desc_r;
endmodule
`default_nettype wire

// ===== rtl/drq_ctrl.sv =====
// sequencer that walks the ring for enqueue, drain and queries
`default_nettype none
module drq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  drq_stream_if.sink              req,
  drq_stream_if.source            res,
  input  wire logic [15:0]        byte_budget,
  input  wire logic [7:0]         line_limit,
  input  wire drq_pkg::desc_t     head_desc,
  input  wire logic               any_busy,
  input  wire logic               probe_busy,
  output logic [5:0]              probe_idx,
  output drq_pkg::ring_ctl_t      ctl,
  output drq_pkg::desc_t          load_desc
);
  typedef enum logic [2:0] {S_IDLE, S_CLEAR, S_ENQ, S_DRAIN, S_OUT} state_t;

  state_t state_r;
  drq_pkg::req_t req_r;
  drq_pkg::res_t res_r;
  logic res_valid_r;
  logic [5:0] rot_r;      // ring rotation: slot at head = rot_r
  logic [6:0] cnt_r;
  logic [16:0] total_r;
  logic drain_any_r;
  logic [16:0] total_sum;
  logic [1:0] enq_op;
  logic drain_go;
  drq_pkg::res_t idle_res;
  drq_pkg::res_t issue_res;
  drq_pkg::res_t stop_res;

  assign req.ready = (state_r == S_IDLE) && !res_valid_r;
  assign res.valid = res_valid_r;
  assign res.data = res_r;
  assign probe_idx = req.data.slot_index - rot_r;
  assign total_sum = total_r + {1'b0, head_desc.size};
  assign enq_op = {!req_r.wide_unit, req_r.req_type == drq_pkg::ReqFill};

  // head slot may be issued by the running drain
  assign drain_go = (head_desc.size != '0) && (total_sum <= {1'b0, byte_budget})
                    && (req_r.scan_line <= line_limit);

  always_comb begin
    load_desc.src = req_r.src_addr;
    load_desc.dest = req_r.dest_addr;
    load_desc.size = req_r.xfer_size;
    load_desc.op = enq_op;
    load_desc.value = req_r.fill_value;
  end

  // result words for queries, issued descriptors and empty drains
  always_comb begin
    idle_res = '0;
    idle_res.last = 1'b1;
    case (req.data.req_type)
      drq_pkg::ReqCheck: idle_res.busy_res = probe_busy;
      drq_pkg::ReqAllEmpty: idle_res.busy_res = any_busy;
      default: idle_res.busy_res = 1'b0;
    endcase
    issue_res = '0;
    issue_res.issued = 1'b1;
    issue_res.out_dest = head_desc.dest;
    issue_res.out_size = head_desc.size;
    issue_res.out_op = head_desc.op;
    if (head_desc.op[0]) issue_res.out_value = head_desc.value;
    else issue_res.out_src = head_desc.src;
    stop_res = '0;
    stop_res.last = 1'b1;
  end

  always_comb begin
    ctl = '0;
    ctl.fill = req_r.req_type == drq_pkg::ReqFill;
    case (state_r)
      S_ENQ: begin
        if (head_desc.size == '0) ctl.load_head = 1'b1;
        else if (cnt_r != 7'd0) ctl.rotate = 1'b1;
      end
      S_DRAIN: begin
        if (drain_go && !res_valid_r)
          ctl.free_head = 1'b1;
      end
      S_OUT: begin
        if (cnt_r != 7'd0) ctl.rotate = 1'b1;
      end
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_valid_r <= 1'b0;
      rot_r <= '0;
      cnt_r <= 7'd64;
      total_r <= '0;
      drain_any_r <= 1'b0;
      res_r <= '0;
      req_r <= '0;
    end else begin
      if (res.valid && res.ready) res_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          // rotating with clear would lose cursor: instead clear in one step
          state_r <= S_IDLE;
          rot_r <= '0;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            req_r <= req.data;
            res_r <= idle_res;
            total_r <= '0;
            drain_any_r <= 1'b0;
            cnt_r <= 7'd63;
            case (req.data.req_type)
              drq_pkg::ReqCopy, drq_pkg::ReqFill: state_r <= S_ENQ;
              drq_pkg::ReqDrain: state_r <= S_DRAIN;
              drq_pkg::ReqCheck, drq_pkg::ReqAllEmpty: res_valid_r <= 1'b1;
              drq_pkg::ReqClear: begin
                state_r <= S_CLEAR;
                rot_r <= '0;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_ENQ: begin
          if (head_desc.size == '0) begin
            // found: head slot is rot_r + steps taken
            res_r.slot_number <= rot_r + 6'(7'd63 - cnt_r);
            state_r <= S_OUT;
            // finish the loop so the cursor slot is back at the head
            cnt_r <= {1'b0, 6'(cnt_r + 7'd1)};
          end else if (cnt_r == 7'd0) begin
            res_r.enqueue_failed <= 1'b1;
            state_r <= S_OUT;
            cnt_r <= 7'd1;
          end else begin
            cnt_r <= cnt_r - 7'd1;
          end
        end
        S_OUT: begin
          // rotate on so the cursor slot is at the head again
          if (cnt_r == 7'd0) begin
            res_valid_r <= 1'b1;
            if (req_r.req_type == drq_pkg::ReqDrain) begin
              res_r.last <= !drain_go;
              state_r <= drain_go ? S_DRAIN : S_IDLE;
            end else begin
              state_r <= S_IDLE;
            end
          end else begin
            cnt_r <= cnt_r - 7'd1;
          end
        end
        S_DRAIN: begin
          if (!res_valid_r) begin
            if (ctl.free_head) begin
              res_r <= issue_res;
              total_r <= total_sum;
              drain_any_r <= 1'b1;
              state_r <= S_OUT;
              cnt_r <= 7'd1;
              rot_r <= rot_r + 6'd1;
            end else begin
              if (!drain_any_r) begin
                res_r <= stop_res;
                res_valid_r <= 1'b1;
              end
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "dma_request_ring_queue_macros.svh"
  `DRQ_ASSERT_IMPL(a_ready_idle, clk, rst_n, req.ready, state_r == S_IDLE)
  `DRQ_ASSERT_IMPL(a_free_rot, clk, rst_n, ctl.free_head, !ctl.rotate && !ctl.load_head)
  `DRQ_ASSERT_NEXT(a_issue_out, clk, rst_n, ctl.free_head, state_r == S_OUT)
endmodule
`default_nettype wire

// ===== rtl/dma_request_ring_queue.sv =====
// Queries are answered straight from idle; an enqueue loads the cursor slot when it is free, else
// the ring rotates forward to the free slot, then on around to the cursor again;
// a drain issues descriptors one at a time, each waiting on the output, until one cannot issue.
// Throughput: one item at a time; the sequencer rotating the cell chain sets the rate.
// Reset: synchronous active low; slots cleared during reset and the cycle after, cursor 0,
// budget 40960 and line limit 224.
`default_nettype none
module dma_request_ring_queue (
  input  wire logic        clk,
  input  wire logic        rst_n,
  drq_stream_if.sink       in_ch,
  drq_stream_if.source     out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [15:0] budget_r;
  logic [7:0] line_r;
  drq_pkg::ring_ctl_t ctl, cell_ctl;
  drq_pkg::desc_t load_desc;
  drq_pkg::desc_t descs [drq_pkg::QueueDepth];
  logic [drq_pkg::QueueDepth-1:0] busy_vec;
  logic [5:0] probe_idx;
  logic rst_clear_r;

  assign cfg_pready = 1'b1;
  always_comb begin
    cfg_prdata = '0;
    case (cfg_paddr[2])
      drq_pkg::RegBudget: cfg_prdata = {16'd0, budget_r};
      drq_pkg::RegLine: cfg_prdata = {24'd0, line_r};
      default: cfg_prdata = '0;
    endcase
  end

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r <= drq_pkg::BudgetReset;
      line_r <= drq_pkg::LineReset;
      rst_clear_r <= 1'b1;
    end else begin
      rst_clear_r <= 1'b0;
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'd0) begin
        if (cfg_paddr[2] == drq_pkg::RegBudget) budget_r <= cfg_pwdata[15:0];
        else line_r <= cfg_pwdata[7:0];
      end
    end
  end

  drq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .req(in_ch), .res(out_ch),
    .byte_budget(budget_r), .line_limit(line_r), .head_desc(descs[0]),
    .any_busy(|busy_vec), .probe_busy(busy_vec[probe_idx]),
    .probe_idx(probe_idx), .ctl(ctl), .load_desc(load_desc)
  );

  // clear request from reset or clear item; rotation in clear state is suppressed
  always_comb begin
    cell_ctl = ctl;
    if (rst_clear_r || (in_ch.valid && in_ch.ready
        && in_ch.data.req_type == drq_pkg::ReqClear)) begin
      cell_ctl = '0;
      cell_ctl.clear = 1'b1;
    end else if (!rst_n) begin
      cell_ctl = '0;
    end
  end

  // ring of cells, each passing its descriptor to the one before it on rotate
  for (genvar g = 0; g < drq_pkg::QueueDepth; g++) begin : g_cell
    drq_cell u_cell (
      .clk(clk), .ctl(cell_ctl), .is_head(g == 0),
      .prev_desc(descs[(g + 1) % drq_pkg::QueueDepth]),
      .load_desc(load_desc), .desc(descs[g])
    );
    assign busy_vec[g] = descs[g].size != '0;
  end
endmodule
`default_nettype wire

// ===== test/tb_dma_request_ring_queue.sv =====
// testbench for the dma request ring queue: random and directed requests against a predictor
`timescale 1ns / 100ps
module tb_dma_request_ring_queue;

  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [2:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  drq_stream_if #(.payload_t(drq_pkg::req_t)) in_ch ();
  drq_stream_if #(.payload_t(drq_pkg::res_t)) out_ch ();

  dma_request_ring_queue i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  // ring mirror and register copies
  logic [31:0] ring_src [drq_pkg::QueueDepth];
  logic [31:0] ring_dst [drq_pkg::QueueDepth];
  logic [15:0] ring_len [drq_pkg::QueueDepth];
  logic [1:0] ring_op [drq_pkg::QueueDepth];
  logic [31:0] ring_pat [drq_pkg::QueueDepth];
  logic [5:0] ring_cursor;
  logic [15:0] budget_reg;
  logic [7:0] line_reg;

  drq_pkg::req_t req_backlog[$];
  drq_pkg::res_t due_results[$];
  int errors = 0;
  int n_enq = 0, n_drain = 0, n_query = 0, n_other = 0, n_issued = 0, n_full = 0;
  int quiet_cycles = 0;
  bit steady = 1'b0;
  bit in_took = 1'b0;

  // expected results of one accepted request
  task automatic apply_request(input drq_pkg::req_t r);
    drq_pkg::res_t e;
    int s;
    logic [16:0] total;
    int cnt;
    e = '0;
    case (r.req_type)
      drq_pkg::ReqCopy, drq_pkg::ReqFill: begin
        n_enq++;
        e.enqueue_failed = 1'b1;
        s = ring_cursor;
        for (int i = 0; i < drq_pkg::QueueDepth; i++) begin
          if (ring_len[s] == 16'd0) begin
            ring_dst[s] = r.dest_addr;
            ring_len[s] = r.xfer_size;
            if (r.req_type == drq_pkg::ReqFill) begin
              ring_pat[s] = r.fill_value;
              ring_op[s] = r.wide_unit ? drq_pkg::OpFill32 : drq_pkg::OpFill16;
            end else begin
              ring_src[s] = r.src_addr;
              ring_op[s] = r.wide_unit ? drq_pkg::OpCopy32 : drq_pkg::OpCopy16;
            end
            e.slot_number = s[5:0];
            e.enqueue_failed = 1'b0;
            break;
          end
          s = (s + 1) % drq_pkg::QueueDepth;
        end
        if (e.enqueue_failed) n_full++;
        e.last = 1'b1;
        due_results.push_back(e);
      end
      drq_pkg::ReqDrain: begin
        n_drain++;
        total = '0;
        cnt = 0;
        for (int i = 0; i < drq_pkg::QueueDepth; i++) begin
          s = ring_cursor;
          if (ring_len[s] == 16'd0) break;
          total = total + {1'b0, ring_len[s]};
          if (total > {1'b0, budget_reg}) break;
          if (r.scan_line > line_reg) break;
          e = '0;
          e.issued = 1'b1;
          e.out_op = ring_op[s];
          e.out_dest = ring_dst[s];
          e.out_size = ring_len[s];
          if (ring_op[s] == drq_pkg::OpFill32 || ring_op[s] == drq_pkg::OpFill16)
            e.out_value = ring_pat[s];
          else e.out_src = ring_src[s];
          due_results.push_back(e);
          cnt++;
          ring_src[s] = '0; ring_dst[s] = '0; ring_len[s] = '0;
          ring_op[s] = '0; ring_pat[s] = '0;
          ring_cursor = ring_cursor + 6'd1;
        end
        n_issued += cnt;
        if (cnt == 0) due_results.push_back('0);
        e = due_results.pop_back();
        e.last = 1'b1;
        due_results.push_back(e);
      end
      drq_pkg::ReqCheck, drq_pkg::ReqAllEmpty: begin
        n_query++;
        if (r.req_type == drq_pkg::ReqCheck) e.busy_res = ring_len[r.slot_index] != 16'd0;
        else foreach (ring_len[i]) if (ring_len[i] != 16'd0) e.busy_res = 1'b1;
        e.last = 1'b1;
        due_results.push_back(e);
      end
      drq_pkg::ReqClear: begin
        n_other++;
        foreach (ring_len[i]) begin
          ring_len[i] = '0; ring_src[i] = '0; ring_dst[i] = '0;
        end
        ring_cursor = '0;
      end
      default: n_other++;
    endcase
  endtask

  task automatic chk_field(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // input acceptance, output check and watchdog
  always @(posedge clk) begin
    drq_pkg::res_t e;
    drq_pkg::res_t a;
    in_took <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      apply_request(req_backlog.pop_front());
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      a = out_ch.data;
      if (due_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = due_results.pop_front();
        chk_field("slot_number", 32'(e.slot_number), 32'(a.slot_number));
        chk_field("enqueue_failed", 32'(e.enqueue_failed), 32'(a.enqueue_failed));
        chk_field("busy_res", 32'(e.busy_res), 32'(a.busy_res));
        chk_field("issued", 32'(e.issued), 32'(a.issued));
        chk_field("out_src", e.out_src, a.out_src);
        chk_field("out_dest", e.out_dest, a.out_dest);
        chk_field("out_size", 32'(e.out_size), 32'(a.out_size));
        chk_field("out_op", 32'(e.out_op), 32'(a.out_op));
        chk_field("out_value", e.out_value, a.out_value);
        chk_field("last", 32'(e.last), 32'(a.last));
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired, %0d results outstanding", due_results.size());
      $display("[dma_request_ring_queue] ERROR");
      $finish;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_took) begin
      in_ch.valid <= 1'b1;
    end else if (req_backlog.size() > 0 && (steady || $urandom_range(99) >= 36)) begin
      in_ch.valid <= 1'b1;
      in_ch.data <= req_backlog[0];
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // result sink with random stalls
  always @(negedge clk) begin
    out_ch.ready <= rst_n && (steady || $urandom_range(99) >= 36);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == drq_pkg::RegBudget) budget_reg = val[15:0];
    else line_reg = val[7:0];
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic drain_out();
    while (req_backlog.size() > 0 || due_results.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic drq_pkg::req_t mk_req(input logic [2:0] kind, input logic [15:0] len,
                                           input logic [7:0] line);
    drq_pkg::req_t r;
    r.req_type = kind;
    r.src_addr = $urandom;
    r.dest_addr = $urandom;
    r.xfer_size = len;
    r.wide_unit = 1'($urandom_range(1));
    r.fill_value = $urandom;
    r.slot_index = 6'($urandom_range(63));
    r.scan_line = line;
    return r;
  endfunction

  function automatic logic [15:0] rand_len();
    int p;
    p = $urandom_range(99);
    if (p < 8) return 16'd0;
    if (p < 80) return 16'($urandom_range(2000, 1));
    if (p < 92) return 16'($urandom_range(20000, 2001));
    return 16'($urandom_range(65535, 20001));
  endfunction

  // mostly enqueues and drains, a few queries, clears and unused codes
  function automatic drq_pkg::req_t rand_req(input int enq_pct);
    int p;
    logic [7:0] line;
    p = $urandom_range(99);
    line = ($urandom_range(9) < 8) ? 8'($urandom_range(line_reg)) : 8'($urandom_range(255));
    if (p < enq_pct) return mk_req(3'($urandom_range(1)), rand_len(), line);
    if (p < 85) return mk_req(drq_pkg::ReqDrain, rand_len(), line);
    if (p < 93)
      return mk_req($urandom_range(1) ? drq_pkg::ReqCheck : drq_pkg::ReqAllEmpty,
                    rand_len(), line);
    if (p < 96) return mk_req(drq_pkg::ReqClear, rand_len(), line);
    return mk_req(3'($urandom_range(7, 6)), rand_len(), line);
  endfunction

  initial begin
    drq_pkg::req_t r;
    foreach (ring_len[i]) begin
      ring_src[i] = '0; ring_dst[i] = '0; ring_len[i] = '0;
      ring_op[i] = '0; ring_pat[i] = '0;
    end
    ring_cursor = '0;
    budget_reg = drq_pkg::BudgetReset;
    line_reg = drq_pkg::LineReset;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (4) @(posedge clk);

    // directed: queries on the empty ring, extreme fields, all request kinds
    req_backlog.push_back(mk_req(drq_pkg::ReqAllEmpty, 16'd0, 8'd0));
    r = mk_req(drq_pkg::ReqCheck, 16'd0, 8'd0); r.slot_index = 6'd0; req_backlog.push_back(r);
    r = mk_req(drq_pkg::ReqCopy, 16'hFFFF, 8'd0);
    r.src_addr = '1; r.dest_addr = '0; r.wide_unit = 1'b1; req_backlog.push_back(r);
    r = mk_req(drq_pkg::ReqFill, 16'd1, 8'd0);
    r.fill_value = '1; r.dest_addr = '1; r.wide_unit = 1'b0; req_backlog.push_back(r);
    // zero length: index reported, slot stays free
    r = mk_req(drq_pkg::ReqCopy, 16'd0, 8'd0); r.wide_unit = 1'b0; req_backlog.push_back(r);
    r = mk_req(drq_pkg::ReqFill, 16'd2, 8'd0); r.fill_value = '0; r.wide_unit = 1'b1;
    req_backlog.push_back(r);
    r = mk_req(drq_pkg::ReqCheck, 16'd0, 8'd0); r.slot_index = 6'd1; req_backlog.push_back(r);
    // line above the limit, then a head slot larger than the budget
    req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd255));
    req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqClear, 16'd0, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqAllEmpty, 16'd0, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqCopy, 16'd100, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqFill, 16'd40860, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqCopy, 16'd1, 8'd0));
    // line equal to the limit issues; total exactly at budget passes
    req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd224));
    req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd0));
    r = mk_req(drq_pkg::ReqCheck, 16'd0, 8'd0); r.slot_index = 6'd63; req_backlog.push_back(r);
    req_backlog.push_back(mk_req(3'd6, 16'd5, 8'd0));
    req_backlog.push_back(mk_req(3'd7, 16'd5, 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqAllEmpty, 16'd0, 8'd0));
    drain_out();

    // widest budget and line limit, 17-bit total can pass 16 bits
    reg_write(drq_pkg::RegBudget, 32'd65535);
    reg_write(drq_pkg::RegLine, 32'd255);
    for (int i = 0; i < 60; i++) req_backlog.push_back(rand_req(55));
    drain_out();

    // zero budget and zero line: drains issue nothing
    reg_write(drq_pkg::RegBudget, 32'd0);
    reg_write(drq_pkg::RegLine, 32'd0);
    for (int i = 0; i < 20; i++) req_backlog.push_back(rand_req(50));
    drain_out();

    // fill the whole ring without idling, overflow it, then empty it
    reg_write(drq_pkg::RegBudget, 32'd40960);
    reg_write(drq_pkg::RegLine, 32'd128);
    steady = 1'b1;
    req_backlog.push_back(mk_req(drq_pkg::ReqClear, 16'd0, 8'd0));
    for (int i = 0; i < 68; i++)
      req_backlog.push_back(mk_req(3'($urandom_range(1)), 16'($urandom_range(600, 1)), 8'd0));
    req_backlog.push_back(mk_req(drq_pkg::ReqAllEmpty, 16'd0, 8'd0));
    for (int i = 0; i < 6; i++) req_backlog.push_back(mk_req(drq_pkg::ReqDrain, 16'd0, 8'd100));
    req_backlog.push_back(mk_req(drq_pkg::ReqAllEmpty, 16'd0, 8'd0));
    drain_out();
    steady = 1'b0;

    // random registers and mixed traffic
    reg_write(drq_pkg::RegBudget, $urandom_range(65535));
    reg_write(drq_pkg::RegLine, $urandom_range(255));
    for (int i = 0; i < 60; i++) req_backlog.push_back(rand_req(60));
    drain_out();

    $display("enqueues %0d (%0d on a full ring), drains %0d issuing %0d descriptors",
             n_enq, n_full, n_drain, n_issued);
    $display("queries %0d, clears and unused codes %0d", n_query, n_other);
    if (errors == 0) begin
      $display("[dma_request_ring_queue] OK");
    end else begin
      $display("[dma_request_ring_queue] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/drq_pkg.sv
rtl/drq_stream_if.sv
rtl/drq_cell.sv
rtl/drq_ctrl.sv
rtl/dma_request_ring_queue.sv
test/tb_dma_request_ring_queue.sv
